@@ design/mmws_pkg.sv @@
package mmws_pkg;

    localparam int STEP_BITS      = 24;
    localparam int AMP_BITS       = 16;
    localparam int TIME_FRAC_BITS = 40;
    localparam int MULT_BITS      = STEP_BITS + 1;

    localparam logic [2:0] REG_WAVE_TYPE  = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE  = 3'd1;
    localparam logic [2:0] REG_FREQUENCY  = 3'd2;
    localparam logic [2:0] REG_PHASE      = 3'd3;
    localparam logic [2:0] REG_STEP_TIME  = 3'd4;
    localparam logic [2:0] REG_SWEEP_LOW  = 3'd5;
    localparam logic [2:0] REG_SWEEP_HIGH = 3'd6;

    // phase in turns: 2^40 = 360 * PHASE_Q + PHASE_R
    localparam logic [31:0] PHASE_Q     = 32'd3054198966;
    localparam logic [4:0]  PHASE_R     = 5'd16;
    localparam logic [13:0] PHASE_RECIP = 14'd11651;

    localparam logic [16:0] SIN_A     = 17'd102944;
    localparam logic [15:0] SIN_B     = 16'd42047;
    localparam logic [12:0] SIN_C     = 13'd4640;
    localparam logic [19:0] PI_SQ_Q16 = 20'd646814;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef enum logic [1:0] {
        WAVE_SINE  = 2'd0,
        WAVE_DELTA = 2'd1,
        WAVE_SWEEP = 2'd2,
        WAVE_GAUSS = 2'd3
    } wave_t;

    typedef struct packed {
        wave_t       wave_type;
        logic [15:0] amplitude;
        logic [15:0] frequency_hz;
        logic [31:0] step_time;
        logic [40:0] phase_turn;
        logic [15:0] sweep_low_hz;
        logic [15:0] sweep_high_hz;
    } cfg_t;

    typedef struct packed {
        wave_t mode;
        logic  kill;
        logic  step_zero;
    } ctrl_t;

    typedef struct packed {
        ctrl_t                ctrl;
        logic [STEP_BITS-1:0] step;
        logic [MULT_BITS-1:0] freq;
    } mid_item_t;

endpackage

@@ design/mmws_fifo.sv @@
module mmws_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int ADDR = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [ADDR:0]    wr_ptr_reg;
    logic [ADDR:0]    rd_ptr_reg;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[ADDR] != rd_ptr_reg[ADDR])
                && (wr_ptr_reg[ADDR-1:0] == rd_ptr_reg[ADDR-1:0]);
    assign rdata = mem[rd_ptr_reg[ADDR-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_ptr_reg[ADDR-1:0]] <= wdata;
    end

endmodule

@@ design/mmws_front.sv @@
module mmws_front
    import mmws_pkg::*;
(
    input  logic                 push,
    input  logic                 queue_full,
    input  logic [STEP_BITS-1:0] sim_step,
    input  cfg_t                 cfg,
    output logic                 accept,
    output mid_item_t            item
);

    logic [MULT_BITS-1:0] sweep_freq;
    logic                 in_band;
    logic                 is_sweep;

    assign accept     = push && !queue_full;
    assign sweep_freq = MULT_BITS'(sim_step) + MULT_BITS'(cfg.frequency_hz)
                      + MULT_BITS'(3);
    assign in_band    = (sweep_freq >= MULT_BITS'(cfg.sweep_low_hz))
                     && (sweep_freq <= MULT_BITS'(cfg.sweep_high_hz));
    assign is_sweep   = (cfg.wave_type == WAVE_SWEEP);

    always_comb
    begin
        item.ctrl.mode      = cfg.wave_type;
        item.ctrl.kill      = is_sweep && !in_band;
        item.ctrl.step_zero = (sim_step == '0);
        item.step           = sim_step;
        item.freq           = is_sweep ? sweep_freq : MULT_BITS'(cfg.frequency_hz);
    end

endmodule

@@ design/mmws_back.sv @@
module mmws_back
    import mmws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue,
    input  mid_item_t           item,
    input  cfg_t                cfg,
    output logic                done,
    output logic [AMP_BITS-1:0] pressure
);

    localparam int STAGES = 14;

    logic [STAGES:1] valid_reg;
    ctrl_t           ctrl_reg [1:STAGES];
    logic [12:4]     far_reg;

    logic [39:0] a_reg;
    logic [63:0] pl_reg;
    logic [39:0] phi_reg;
    logic [71:0] p_reg;
    logic [39:0] turns_reg;
    logic [16:0] dq_reg;

    logic [16:0] x_reg [5:8];
    logic [9:5]  neg_reg;
    logic [16:0] x2_reg [6:7];
    logic [15:0] t_reg;
    logic [16:0] u_reg;
    logic [17:0] s_reg;
    logic signed [15:0] ws_reg [10:12];

    logic [17:0] d2_reg;
    logic [21:0] e_reg;
    logic [22:0] y_reg;
    logic [15:0] f_reg [8:11];
    logic [3:0]  sh_reg [8:12];
    logic [9:0]  poly1_reg;
    logic [11:0] poly2_reg;
    logic [13:0] poly3_reg;
    logic [15:0] poly4_reg;
    logic [16:0] poly5_reg;

    logic signed [15:0] w_reg;
    logic signed [31:0] prod_reg;

    logic [2*MULT_BITS-2:0] a_full;
    logic [40:0] tsum;
    logic [41:0] d4;
    logic [33:0] xx;
    logic [29:0] ct;
    logic [32:0] tu;
    logic [33:0] xs;
    logic [18:0] sr;
    logic [14:0] mq;
    logic [33:0] dd;
    logic [37:0] ee;
    logic [38:0] yy;
    logic [22:0] fp1;
    logic [25:0] fp2;
    logic [27:0] fp3;
    logic [29:0] fp4;
    logic [31:0] fp5;
    logic [17:0] gsum;
    logic [14:0] gq;
    logic signed [15:0] w_next;
    logic [31:0] mag;
    logic [16:0] rnd;
    logic signed [17:0] sval;
    logic [AMP_BITS-1:0] scaled;

    localparam logic [41:0] ONE_TURN = 42'(1) << TIME_FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[STAGES-1:1], issue};
    end

    assign a_full = (2*MULT_BITS-1)'(item.freq) * (2*MULT_BITS-1)'(item.step);
    assign tsum   = 41'(p_reg[39:0]) + cfg.phase_turn;
    assign d4     = (p_reg[41:0] < ONE_TURN) ? ONE_TURN - p_reg[41:0]
                                             : p_reg[41:0] - ONE_TURN;
    assign xx     = 34'(x_reg[5]) * 34'(x_reg[5]);
    assign ct     = 30'(SIN_C) * 30'(x2_reg[6]);
    assign tu     = 33'(t_reg) * 33'(x2_reg[7]);
    assign xs     = 34'(x_reg[8]) * 34'(u_reg);
    assign sr     = (19'(s_reg) + 19'd1) >> 1;
    assign mq     = (sr > 19'd32767) ? 15'h7FFF : sr[14:0];
    assign dd     = 34'(dq_reg) * 34'(dq_reg);
    assign ee     = 38'(d2_reg) * 38'(PI_SQ_Q16);
    assign yy     = 39'(e_reg) * 39'(LOG2E_Q16);
    assign fp1    = 23'(y_reg[15:0]) * 23'd78;
    assign fp2    = 26'(f_reg[8]) * 26'(poly1_reg);
    assign fp3    = 28'(f_reg[9]) * 28'(poly2_reg);
    assign fp4    = 30'(f_reg[10]) * 30'(poly3_reg);
    assign fp5    = 32'(f_reg[11]) * 32'(poly4_reg);
    assign gsum   = (18'(poly5_reg >> sh_reg[12]) + 18'd1) >> 1;
    assign gq     = (gsum > 18'd32767) ? 15'h7FFF : gsum[14:0];

    always_comb
    begin
        unique case (ctrl_reg[12].mode)
            WAVE_SINE:  w_next = ws_reg[12];
            WAVE_SWEEP: w_next = ctrl_reg[12].kill ? 16'sd0 : ws_reg[12];
            WAVE_GAUSS: w_next = far_reg[12] ? 16'sd0 : $signed({1'b0, gq});
            default:    w_next = 16'sd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg[1] <= item.ctrl;
        for (int i = 2; i <= STAGES; i++)
            ctrl_reg[i] <= ctrl_reg[i-1];

        a_reg   <= a_full[39:0];
        pl_reg  <= 64'(a_reg[31:0]) * 64'(cfg.step_time);
        phi_reg <= 40'(a_reg[39:32]) * 40'(cfg.step_time);
        p_reg   <= 72'(pl_reg) + {phi_reg, 32'b0};

        turns_reg  <= tsum[39:0];
        far_reg[4] <= (p_reg[71:40] >= 32'd3);
        dq_reg     <= d4[40:24];

        x_reg[5]   <= turns_reg[38] ? 17'd65536 - 17'(turns_reg[37:22])
                                    : 17'(turns_reg[37:22]);
        neg_reg[5] <= turns_reg[39];
        d2_reg     <= dd[33:16];
        far_reg[5] <= far_reg[4];

        x_reg[6]   <= x_reg[5];
        x2_reg[6]  <= xx[32:16];
        e_reg      <= ee[37:16];

        x_reg[7]   <= x_reg[6];
        x2_reg[7]  <= x2_reg[6];
        t_reg      <= SIN_B - 16'(ct[29:16]);
        y_reg      <= yy[38:16];

        x_reg[8]   <= x_reg[7];
        u_reg      <= SIN_A - 17'(tu[32:16]);
        far_reg[8] <= far_reg[7] | (y_reg[22:20] != 3'd0);
        f_reg[8]   <= y_reg[15:0];
        sh_reg[8]  <= y_reg[19:16];
        poly1_reg  <= 10'd630 - 10'(fp1[22:16]);

        s_reg      <= xs[33:16];
        poly2_reg  <= 12'd3638 - 12'(fp2[25:16]);

        ws_reg[10] <= neg_reg[9] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
        poly3_reg  <= 14'd15744 - 14'(fp3[27:16]);

        ws_reg[11] <= ws_reg[10];
        poly4_reg  <= 16'd45426 - 16'(fp4[29:16]);

        ws_reg[12] <= ws_reg[11];
        poly5_reg  <= 17'd65536 - 17'(fp5[31:16]);

        neg_reg[9:6]  <= neg_reg[8:5];
        far_reg[7:6]  <= far_reg[6:5];
        far_reg[12:9] <= far_reg[11:8];
        for (int i = 9; i <= 11; i++)
            f_reg[i] <= f_reg[i-1];
        for (int i = 9; i <= 12; i++)
            sh_reg[i] <= sh_reg[i-1];

        w_reg    <= w_next;
        prod_reg <= 32'($signed(cfg.amplitude) * w_reg);
    end

    // round half away from zero, then saturate
    assign mag  = prod_reg[31] ? 32'(-prod_reg) : 32'(prod_reg);
    assign rnd  = 17'((mag + 32'd16384) >> 15);
    assign sval = prod_reg[31] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

    always_comb
    begin
        if (sval > 18'sd32767)
            scaled = 16'h7FFF;
        else if (sval < -18'sd32768)
            scaled = 16'h8000;
        else
            scaled = sval[15:0];
    end

    assign done     = valid_reg[STAGES];
    assign pressure = (ctrl_reg[STAGES].mode == WAVE_DELTA)
                    ? (ctrl_reg[STAGES].step_zero ? cfg.amplitude : '0)
                    : scaled;

endmodule

@@ design/multi_mode_wave_source_core.sv @@
// A push passes mid queue, back pipeline and output queue before empty goes low.
// Throughput: one beat per cycle while output slots last; 14-stage fixed-point
// datapath (multipliers for phase, quarter-wave sine and the 2^-y polynomial).
// Up to 32 results are held in the output queue; a full output side stalls input.
// Reset: asynchronous, active low; queues empty, registers back to their defaults.
module multi_mode_wave_source_core
    import mmws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [STEP_BITS-1:0] sim_step,
    output logic                 empty,
    input  logic                 pop,
    output logic [AMP_BITS-1:0]  pressure,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 32;
    localparam int CNT_BITS  = $clog2(OUT_DEPTH) + 1;

    wave_t       wave_type_reg;
    logic [15:0] amplitude_reg;
    logic [15:0] frequency_reg;
    logic [8:0]  phase_reg;
    logic [31:0] step_time_reg;
    logic [15:0] sweep_low_reg;
    logic [15:0] sweep_high_reg;
    logic [40:0] phase_turn_reg;
    logic [40:0] phase_turn_next;
    logic [27:0] phase_frac;

    logic [CNT_BITS-1:0] reserved_reg;
    logic [CNT_BITS-1:0] reserved_next;

    cfg_t      cfg;
    mid_item_t front_item;
    mid_item_t mid_head;
    logic      front_accept;
    logic      mid_full;
    logic      mid_empty;
    logic      issue;
    logic      done;
    logic [AMP_BITS-1:0] back_pressure;
    logic      out_full;
    logic      pop_beat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_type_reg  <= WAVE_SINE;
            amplitude_reg  <= 16'd256;
            frequency_reg  <= 16'd1000;
            phase_reg      <= '0;
            step_time_reg  <= '0;
            sweep_low_reg  <= '0;
            sweep_high_reg <= 16'hFFFF;
            phase_turn_reg <= '0;
        end
        else
        begin
            phase_turn_reg <= phase_turn_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_WAVE_TYPE:  wave_type_reg  <= wave_t'(cfg_data[1:0]);
                    REG_AMPLITUDE:  amplitude_reg  <= cfg_data[15:0];
                    REG_FREQUENCY:  frequency_reg  <= cfg_data[15:0];
                    REG_PHASE:      phase_reg      <= cfg_data[8:0];
                    REG_STEP_TIME:  step_time_reg  <= cfg_data;
                    REG_SWEEP_LOW:  sweep_low_reg  <= cfg_data[15:0];
                    REG_SWEEP_HIGH: sweep_high_reg <= cfg_data[15:0];
                    default:        ;
                endcase
            end
        end
    end

    // round(phase * 2^40 / 360) split as phase*q + round(phase*r/360)
    assign phase_frac      = (28'(phase_reg) * 28'(PHASE_R) + 28'd180) * 28'(PHASE_RECIP);
    assign phase_turn_next = 41'(phase_reg) * 41'(PHASE_Q) + 41'(phase_frac[27:22]);

    always_comb
    begin
        cfg.wave_type     = wave_type_reg;
        cfg.amplitude     = amplitude_reg;
        cfg.frequency_hz  = frequency_reg;
        cfg.step_time     = step_time_reg;
        cfg.phase_turn    = phase_turn_reg;
        cfg.sweep_low_hz  = sweep_low_reg;
        cfg.sweep_high_hz = sweep_high_reg;
    end

    mmws_front u_front (
        .push       (push),
        .queue_full (mid_full),
        .sim_step   (sim_step),
        .cfg        (cfg),
        .accept     (front_accept),
        .item       (front_item)
    );

    assign full = mid_full;

    mmws_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_accept),
        .wdata (front_item),
        .full  (mid_full),
        .pop   (issue),
        .rdata (mid_head),
        .empty (mid_empty)
    );

    // slots reserved in the output queue for beats in flight
    assign pop_beat      = pop && !empty;
    assign issue         = !mid_empty && (reserved_reg < CNT_BITS'(OUT_DEPTH));
    assign reserved_next = reserved_reg + CNT_BITS'(issue) - CNT_BITS'(pop_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reserved_reg <= '0;
        else
            reserved_reg <= reserved_next;
    end

    mmws_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .item     (mid_head),
        .cfg      (cfg),
        .done     (done),
        .pressure (back_pressure)
    );

    mmws_fifo #(
        .WIDTH (AMP_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (done),
        .wdata (back_pressure),
        .full  (out_full),
        .pop   (pop),
        .rdata (pressure),
        .empty (empty)
    );

endmodule

@@ tb/tb_multi_mode_wave_source_core.sv @@
module tb_multi_mode_wave_source_core;
    import mmws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam longint unsigned ONE_TURN = 64'd1 << TIME_FRAC_BITS;
    localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [STEP_BITS-1:0] sim_step;
    logic                 empty;
    logic                 pop;
    logic [AMP_BITS-1:0]  pressure;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [31:0]          cfg_data;

    // shadow copy of the source settings
    wave_t       sh_wave;
    logic [15:0] sh_amp;
    logic [15:0] sh_freq;
    logic [8:0]  sh_phase;
    logic [31:0] sh_dt;
    logic [15:0] sh_lo;
    logic [15:0] sh_hi;

    logic [AMP_BITS-1:0] pressure_due[$];
    int  errors;
    int  push_idle_pct;
    int  pop_idle_pct;
    int  pop_hold;

    multi_mode_wave_source_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sim_step  (sim_step),
        .empty     (empty),
        .pop       (pop),
        .pressure  (pressure),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int quarter_sine(longint unsigned x);
        longint unsigned x2, t, u, s;
        x2 = (x * x) >> 16;
        t  = 64'd42047 - ((64'd4640 * x2) >> 16);
        u  = 64'd102944 - ((t * x2) >> 16);
        s  = (x * u) >> 16;
        s  = (s + 1) >> 1;
        if (s > 32767)
            s = 32767;
        return int'(s);
    endfunction

    function automatic int sine_of_turn(longint unsigned turn);
        longint unsigned t18, x;
        int m;
        t18 = (turn >> (TIME_FRAC_BITS - 18)) & 64'h3FFFF;
        x   = t18 & 64'hFFFF;
        if (t18[16])
            x = 64'd65536 - x;
        m = quarter_sine(x);
        return t18[17] ? -m : m;
    endfunction

    function automatic int sine_at(longint unsigned f, longint unsigned n);
        longint unsigned turns, ph;
        turns = (f * n) * longint'(sh_dt);
        ph    = ((longint'(sh_phase) << TIME_FRAC_BITS) + 180) / 360;
        return sine_of_turn((turns + ph) & (ONE_TURN - 1));
    endfunction

    function automatic int gauss_at(longint unsigned n);
        logic [95:0] wide;
        longint unsigned a, p, d, dq, d2, e, y, f, poly, w;
        int sh;
        a    = longint'(sh_freq) * n;
        wide = {32'd0, a} * {64'd0, sh_dt};
        if (wide[95:64] != 0)
            return 0;
        p = wide[63:0];
        if (p >= 3 * ONE_TURN)
            return 0;
        d  = (p < ONE_TURN) ? ONE_TURN - p : p - ONE_TURN;
        dq = d >> (TIME_FRAC_BITS - 16);
        d2 = (dq * dq) >> 16;
        e  = (d2 * 64'd646814) >> 16;
        y  = (e * 64'd94548) >> 16;
        if ((y >> 16) >= 16)
            return 0;
        sh   = int'(y >> 16);
        f    = y & 64'hFFFF;
        poly = 64'd630 - ((f * 64'd78) >> 16);
        poly = 64'd3638 - ((f * poly) >> 16);
        poly = 64'd15744 - ((f * poly) >> 16);
        poly = 64'd45426 - ((f * poly) >> 16);
        poly = 64'd65536 - ((f * poly) >> 16);
        w    = ((poly >> sh) + 1) >> 1;
        if (w > 32767)
            w = 32767;
        return int'(w);
    endfunction

    function automatic logic [AMP_BITS-1:0] scale_q15(int w);
        longint prod, mag, v;
        prod = longint'($signed(sh_amp)) * longint'(w);
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + (64'sd1 << 14)) >>> 15;
        v    = (prod < 0) ? -mag : mag;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[AMP_BITS-1:0];
    endfunction

    function automatic logic [AMP_BITS-1:0] pressure_at(logic [STEP_BITS-1:0] step);
        longint unsigned n, fs;
        int w;
        n = step;
        w = 0;
        case (sh_wave)
            WAVE_SINE:  w = sine_at(sh_freq, n);
            WAVE_DELTA: return (n == 0) ? sh_amp : '0;
            WAVE_SWEEP:
            begin
                fs = n + sh_freq + 3;
                if (fs >= sh_lo && fs <= sh_hi)
                    w = sine_at(fs, n);
            end
            default:    w = gauss_at(n);
        endcase
        return scale_q15(w);
    endfunction

    // result side: random pop, optional long hold-off, in-order check
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pressure_due.size() == 0)
            begin
                $display("%0t: unexpected result, actual %0d", $time, $signed(pressure));
                errors++;
            end
            else
            begin
                if (pressure !== pressure_due[0])
                begin
                    $display("%0t: pressure mismatch, expected %0d actual %0d", $time,
                             $signed(pressure_due[0]), $signed(pressure));
                    errors++;
                end
                void'(pressure_due.pop_front());
            end
        end
        if (pop_hold > 0)
        begin
            pop_hold--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_WAVE_TYPE:  sh_wave  = wave_t'(data[1:0]);
            REG_AMPLITUDE:  sh_amp   = data[15:0];
            REG_FREQUENCY:  sh_freq  = data[15:0];
            REG_PHASE:      sh_phase = data[8:0];
            REG_STEP_TIME:  sh_dt    = data;
            REG_SWEEP_LOW:  sh_lo    = data[15:0];
            REG_SWEEP_HIGH: sh_hi    = data[15:0];
            default:        ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_step(logic [STEP_BITS-1:0] step);
        if ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        sim_step <= step;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pressure_due.push_back(pressure_at(step));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pressure_due.size() != 0)
            @(posedge clk);
        repeat (24)
            @(posedge clk);
    endtask

    task automatic set_source(wave_t wv, logic [15:0] amp, logic [15:0] f, logic [8:0] ph,
                              logic [31:0] dt);
        cfg_write(REG_WAVE_TYPE, {30'd0, wv});
        cfg_write(REG_AMPLITUDE, {{16{amp[15]}}, amp});
        cfg_write(REG_FREQUENCY, {16'($urandom), f});
        cfg_write(REG_PHASE, {23'($urandom), ph});
        cfg_write(REG_STEP_TIME, dt);
    endtask

    task automatic test_defaults();
        send_step('0);
        send_step(24'd12345);
        send_step(STEP_MAX);
        drain();
    endtask

    task automatic test_directed();
        set_source(WAVE_DELTA, 16'h8000, 16'd1000, 9'd0, 32'd0);
        send_step('0);
        send_step(24'd1);
        send_step(STEP_MAX);
        drain();
        set_source(WAVE_SINE, 16'h7FFF, 16'd0, 9'd90, 32'd0);
        send_step('0);
        send_step(STEP_MAX);
        drain();
        cfg_write(REG_PHASE, 32'd400);
        send_step(24'd5);
        drain();
        cfg_write(REG_PHASE, 32'd511);
        send_step(24'd5);
        drain();
        set_source(WAVE_SINE, 16'h8000, 16'hFFFF, 9'd360, 32'hFFFF_FFFF);
        send_step(STEP_MAX);
        send_step(24'd1);
        drain();
        set_source(WAVE_SWEEP, 16'h0100, 16'd100, 9'd0, 32'd1 << 24);
        cfg_write(REG_SWEEP_LOW, 32'd105);
        cfg_write(REG_SWEEP_HIGH, 32'd107);
        send_step(24'd1);
        send_step(24'd2);
        send_step(24'd4);
        send_step(24'd5);
        drain();
        cfg_write(REG_SWEEP_LOW, 32'd200);
        cfg_write(REG_SWEEP_HIGH, 32'd100);
        send_step(24'd150);
        drain();
        set_source(WAVE_GAUSS, 16'h7FFF, 16'd1000, 9'd0, 32'd0);
        send_step(24'd3);
        drain();
        cfg_write(REG_STEP_TIME, 32'd1099512);
        send_step(24'd1);
        send_step(24'd0);
        send_step(24'd3);
        drain();
        cfg_write(REG_FREQUENCY, 32'hFFFF);
        cfg_write(REG_STEP_TIME, 32'hFFFF_FFFF);
        send_step(STEP_MAX);
        drain();
        cfg_write(REG_UNUSED, $urandom);
        send_step(24'd2);
        drain();
    endtask

    task automatic random_phase(wave_t wv, int items);
        logic [15:0] f;
        logic [31:0] dt;
        int span;
        longint unsigned denom;
        f    = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 5000));
        span = $urandom_range(1, 2000);
        if (wv == WAVE_GAUSS)
        begin
            denom = longint'(f == 0 ? 1 : f) * span;
            dt    = (ONE_TURN / denom > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                     : 32'(ONE_TURN / denom);
        end
        else
            dt = $urandom >> $urandom_range(0, 31);
        set_source(wv, 16'($urandom), f, 9'($urandom), dt);
        cfg_write(REG_SWEEP_LOW, {16'd0, 16'(f + 3 + $urandom_range(0, span))});
        cfg_write(REG_SWEEP_HIGH, 32'(sh_lo + $urandom_range(0, span)) & 32'hFFFF);
        if ($urandom_range(3) == 0)
            cfg_write(REG_UNUSED, $urandom);
        repeat (items)
        begin
            case ($urandom_range(0, 3))
                0:       send_step(STEP_BITS'($urandom));
                1:       send_step('0);
                default: send_step(STEP_BITS'($urandom_range(0, 3 * span)));
            endcase
        end
        drain();
    endtask

    task automatic test_random();
        for (int i = 0; i < 12; i++)
        begin
            if (i == 5)
            begin
                push_idle_pct = 0;
                pop_idle_pct  = 0;
            end
            else
            begin
                push_idle_pct = 20;
                pop_idle_pct  = 20;
            end
            random_phase(wave_t'(i % 4), 150);
        end
        push_idle_pct = 20;
        pop_idle_pct  = 20;
    endtask

    task automatic test_backpressure();
        set_source(WAVE_SINE, 16'($urandom), 16'($urandom), 9'($urandom), $urandom);
        pop_hold = 300;
        repeat (120)
            send_step(STEP_BITS'($urandom));
        drain();
    endtask

    initial
    begin
        errors        = 0;
        push_idle_pct = 20;
        pop_idle_pct  = 20;
        pop_hold      = 0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        sim_step      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        sh_wave       = WAVE_SINE;
        sh_amp        = 16'd256;
        sh_freq       = 16'd1000;
        sh_phase      = '0;
        sh_dt         = '0;
        sh_lo         = '0;
        sh_hi         = 16'hFFFF;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_directed();
        test_random();
        test_backpressure();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
